@@ rtl/srf_pkg.sv @@
// Types and constants shared by the SPI register access framer.
`timescale 1ns / 1ps
package srf_pkg;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_RX    = 2'd2,
    KIND_RESET = 2'd3
  } kind_t;

  localparam logic OKIND_TX  = 1'b0;
  localparam logic OKIND_RES = 1'b1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_RESIDUE  = 2'd2;

  localparam logic [7:0] READ_BIT   = 8'h40;
  localparam logic [7:0] CRC_INIT   = 8'hFF;
  localparam logic [7:0] FILL_BYTE  = 8'h00;
  localparam logic [7:0] RESET_BYTE = 8'hFF;
  localparam logic [7:0] CRC_POLY_RST = 8'h07;
  localparam logic [2:0] VALUE_BYTES = 3'd4;

  typedef struct packed {
    kind_t       kind;
    logic [5:0]  reg_address;
    logic [2:0]  byte_count;
    logic [31:0] write_value;
    logic [7:0]  rx_byte;
  } in_t;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  tx_byte;
    logic        frame_last;
    logic [31:0] read_value;
    logic        crc_error;
  } out_t;

  typedef struct packed {
    logic       crc_enable;
    logic [7:0] crc_polynomial;
    logic [7:0] crc_residue_expected;
  } cfg_t;

  typedef enum logic [2:0] {
    SEL_CMD  = 3'd0,
    SEL_DATA = 3'd1,
    SEL_CRC  = 3'd2,
    SEL_FILL = 3'd3,
    SEL_FF   = 3'd4,
    SEL_RES  = 3'd5
  } sel_t;

  typedef struct packed {
    logic accept;
    logic emit;
    sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic tx_last;
    logic data_last;
    logic res_due;
  } status_t;

endpackage

@@ rtl/srf_ctrl.sv @@
// Frame sequencing state machine for the SPI register access framer.
`timescale 1ns / 1ps
module srf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  srf_pkg::kind_t  in_kind,
  output logic            in_ready,
  input  srf_pkg::status_t status,
  output srf_pkg::cmd_t   cmd
);
  import srf_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_WCMD  = 8'b0000_0010,
    S_WDATA = 8'b0000_0100,
    S_WCRC  = 8'b0000_1000,
    S_RCMD  = 8'b0001_0000,
    S_FILL  = 8'b0010_0000,
    S_RST   = 8'b0100_0000,
    S_RX    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd.accept = in_valid && in_ready;
    cmd.emit   = 1'b0;
    cmd.sel    = SEL_FILL;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_kind)
            KIND_WRITE: state_nxt = S_WCMD;
            KIND_READ:  state_nxt = S_RCMD;
            KIND_RX:    state_nxt = S_RX;
            KIND_RESET: state_nxt = S_RST;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_WCMD: begin
        cmd.sel = SEL_CMD;
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = status.tx_last ? S_IDLE : S_WDATA;
        end
      end
      S_WDATA: begin
        cmd.sel = SEL_DATA;
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.tx_last) begin
            state_nxt = S_IDLE;
          end else if (status.data_last) begin
            state_nxt = S_WCRC;
          end
        end
      end
      S_WCRC: begin
        cmd.sel = SEL_CRC;
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_RCMD: begin
        cmd.sel = SEL_CMD;
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = status.tx_last ? S_IDLE : S_FILL;
        end
      end
      S_FILL: begin
        cmd.sel = SEL_FILL;
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.tx_last) state_nxt = S_IDLE;
        end
      end
      S_RST: begin
        cmd.sel = SEL_FF;
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.tx_last) state_nxt = S_IDLE;
        end
      end
      S_RX: begin
        cmd.sel = SEL_RES;
        if (!status.res_due) begin
          state_nxt = S_IDLE;
        end else if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/srf_dp.sv @@
// Datapath: frame bytes, CRC-8 units, read gathering and the output register.
`timescale 1ns / 1ps
module srf_dp #(
  parameter int MAX_DATA_BYTES   = 4,
  parameter int RESET_BYTE_COUNT = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  srf_pkg::in_t      in_data,
  input  srf_pkg::cfg_t     cfg,
  input  srf_pkg::cmd_t     cmd,
  output srf_pkg::status_t  status,
  output logic              out_valid,
  input  logic              out_ready,
  output srf_pkg::out_t     out_data
);
  import srf_pkg::*;

  localparam int FRAME_MAX = MAX_DATA_BYTES + 2;
  localparam int TX_MAX    = (RESET_BYTE_COUNT > FRAME_MAX) ? RESET_BYTE_COUNT : FRAME_MAX;
  localparam int TXW       = $clog2(TX_MAX + 1);

  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data,
                                          input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ((c << 1) ^ poly) : (c << 1);
    end
    return c;
  endfunction

  logic [7:0]     cmd_byte_r, cmd_byte_nxt;
  logic [31:0]    val_r, val_nxt;
  logic [2:0]     dcnt_r, dcnt_nxt;
  logic [TXW-1:0] tx_left_r, tx_left_nxt;
  logic [7:0]     tcrc_r, tcrc_nxt;
  logic [2:0]     rd_left_r, rd_left_nxt;
  logic           chk_r, chk_nxt;
  logic [31:0]    acc_r, acc_nxt;
  logic [7:0]     rcrc_r, rcrc_nxt;
  logic           err_r, err_nxt;
  logic           due_r, due_nxt;
  logic           out_valid_r, out_valid_nxt;
  out_t           out_data_r, out_data_nxt;

  logic [2:0] cnt;
  logic [2:0] pad_bytes;
  logic [4:0] shamt;
  logic [7:0] rx_crc;
  logic [7:0] tx_in;
  logic [7:0] tx_crc;
  logic       out_free;

  // clamp register size to 1..MAX_DATA_BYTES
  always_comb begin
    if (in_data.byte_count == 3'd0) begin
      cnt = 3'd1;
    end else if (in_data.byte_count > 3'(MAX_DATA_BYTES)) begin
      cnt = 3'(MAX_DATA_BYTES);
    end else begin
      cnt = in_data.byte_count;
    end
  end

  // left-justify the used bytes so the MSB byte sits in [31:24]
  assign pad_bytes = VALUE_BYTES - cnt;
  assign shamt     = {pad_bytes[1:0], 3'b000};

  assign rx_crc   = crc_feed(rcrc_r, in_data.rx_byte, cfg.crc_polynomial);
  assign tx_in    = (cmd.sel == SEL_CMD) ? cmd_byte_r : val_r[31:24];
  assign tx_crc   = crc_feed(tcrc_r, tx_in, cfg.crc_polynomial);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    cmd_byte_nxt  = cmd_byte_r;
    val_nxt       = val_r;
    dcnt_nxt      = dcnt_r;
    tx_left_nxt   = tx_left_r;
    tcrc_nxt      = tcrc_r;
    rd_left_nxt   = rd_left_r;
    chk_nxt       = chk_r;
    acc_nxt       = acc_r;
    rcrc_nxt      = rcrc_r;
    err_nxt       = err_r;
    due_nxt       = due_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cmd.accept) begin
      case (in_data.kind)
        KIND_RX: begin
          due_nxt = 1'b0;
          err_nxt = 1'b0;
          if (rd_left_r != 3'd0) begin
            acc_nxt     = {acc_r[23:0], in_data.rx_byte};
            rcrc_nxt    = rx_crc;
            rd_left_nxt = rd_left_r - 3'd1;
            due_nxt     = (rd_left_r == 3'd1) && !chk_r;
          end else if (chk_r) begin
            rcrc_nxt = rx_crc;
            due_nxt  = 1'b1;
            err_nxt  = (rx_crc != cfg.crc_residue_expected);
          end
        end
        KIND_RESET: begin
          rd_left_nxt = 3'd0;
          chk_nxt     = 1'b0;
          acc_nxt     = '0;
          rcrc_nxt    = CRC_INIT;
          tx_left_nxt = TXW'(RESET_BYTE_COUNT);
        end
        default: begin
          // write or read request; either abandons a pending read
          rd_left_nxt  = 3'd0;
          chk_nxt      = 1'b0;
          acc_nxt      = '0;
          rcrc_nxt     = CRC_INIT;
          cmd_byte_nxt = {2'b00, in_data.reg_address};
          val_nxt      = in_data.write_value << shamt;
          dcnt_nxt     = cnt;
          tx_left_nxt  = TXW'(cnt) + TXW'(1) + TXW'(cfg.crc_enable);
          tcrc_nxt     = CRC_INIT;
          if (in_data.kind == KIND_READ) begin
            cmd_byte_nxt = READ_BIT | {2'b00, in_data.reg_address};
            rd_left_nxt  = cnt;
            chk_nxt      = cfg.crc_enable;
          end
        end
      endcase
    end

    if (cmd.emit) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.out_kind    = OKIND_TX;
      out_data_nxt.tx_byte     = FILL_BYTE;
      out_data_nxt.frame_last  = (tx_left_r == TXW'(1));
      out_data_nxt.read_value  = '0;
      out_data_nxt.crc_error   = 1'b0;
      tx_left_nxt              = tx_left_r - TXW'(1);
      case (cmd.sel)
        SEL_CMD: begin
          out_data_nxt.tx_byte = cmd_byte_r;
          tcrc_nxt             = tx_crc;
        end
        SEL_DATA: begin
          out_data_nxt.tx_byte = val_r[31:24];
          tcrc_nxt             = tx_crc;
          val_nxt              = {val_r[23:0], 8'h00};
          dcnt_nxt             = dcnt_r - 3'd1;
        end
        SEL_CRC:  out_data_nxt.tx_byte = ~tcrc_r;
        SEL_FILL: out_data_nxt.tx_byte = FILL_BYTE;
        SEL_FF:   out_data_nxt.tx_byte = RESET_BYTE;
        SEL_RES: begin
          out_data_nxt.out_kind   = OKIND_RES;
          out_data_nxt.frame_last = 1'b0;
          out_data_nxt.read_value = acc_r;
          out_data_nxt.crc_error  = err_r;
          tx_left_nxt             = tx_left_r;
          rd_left_nxt             = 3'd0;
          chk_nxt                 = 1'b0;
          acc_nxt                 = '0;
          rcrc_nxt                = CRC_INIT;
          due_nxt                 = 1'b0;
        end
        default: out_data_nxt.tx_byte = FILL_BYTE;
      endcase
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r      <= 3'd0;
      tx_left_r   <= '0;
      rd_left_r   <= 3'd0;
      chk_r       <= 1'b0;
      acc_r       <= '0;
      rcrc_r      <= CRC_INIT;
      err_r       <= 1'b0;
      due_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      dcnt_r      <= dcnt_nxt;
      tx_left_r   <= tx_left_nxt;
      rd_left_r   <= rd_left_nxt;
      chk_r       <= chk_nxt;
      acc_r       <= acc_nxt;
      rcrc_r      <= rcrc_nxt;
      err_r       <= err_nxt;
      due_r       <= due_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_byte_r <= cmd_byte_nxt;
    val_r      <= val_nxt;
    tcrc_r     <= tcrc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign status.out_free  = out_free;
  assign status.tx_last   = (tx_left_r == TXW'(1));
  assign status.data_last = (dcnt_r == 3'd1);
  assign status.res_due   = due_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/spi_register_access_framer_crc8.sv @@
// Top level of the SPI register access framer with CRC-8: config registers and wiring.
//
//   channel  ports                          beat
//   input    in_valid / in_ready / in_data  one request or one received byte
//   output   out_valid / out_ready / out_data  one transmit byte or one read result
//   config   cfg_wen / cfg_index / cfg_data  one register write, no wait
//
// A request is accepted, then its frame bytes follow: write and read frames are
// 1 + byte_count bytes (+1 with CRC), a reset frame RESET_BYTE_COUNT bytes.
// A received byte emits a read result when one is due. Bytes leave one per cycle from
// the output register; a stall on out_ready holds the sequencer. in_ready is high only
// while the sequencer is idle. Reset is synchronous and needs no clearing pass.
`timescale 1ns / 1ps
module spi_register_access_framer_crc8 #(
  parameter int MAX_DATA_BYTES   = 4,
  parameter int RESET_BYTE_COUNT = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  srf_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output srf_pkg::out_t                     out_data,
  input  logic                              cfg_wen,
  input  logic [srf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [srf_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import srf_pkg::*;

  cfg_t    cfg_r, cfg_nxt;
  cmd_t    cmd;
  status_t status;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wen) begin
      case (cfg_index)
        CFG_CRC_ENABLE:  cfg_nxt.crc_enable           = cfg_data[0];
        CFG_CRC_POLY:    cfg_nxt.crc_polynomial       = cfg_data;
        CFG_CRC_RESIDUE: cfg_nxt.crc_residue_expected = cfg_data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.crc_enable           <= 1'b0;
      cfg_r.crc_polynomial       <= CRC_POLY_RST;
      cfg_r.crc_residue_expected <= 8'h00;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  srf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  srf_dp #(
    .MAX_DATA_BYTES   (MAX_DATA_BYTES),
    .RESET_BYTE_COUNT (RESET_BYTE_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // after an accepted beat the sequencer is busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after an accepted beat");

  // no transmit bytes are owed while idle
  a_idle_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !status.tx_last)
    else $error("idle with frame bytes still owed");

  // emits only happen into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> status.out_free && !cmd.accept)
    else $error("emit into a busy output register");

  // a read result carries no transmit byte
  a_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && cmd.sel == SEL_RES |=> out_data.tx_byte == 8'h00 && !out_data.frame_last)
    else $error("read result with transmit fields set");
`endif

endmodule

@@ tb/spi_register_access_framer_crc8_tb.sv @@
// Self-checking testbench for the SPI register access framer with CRC-8.
`timescale 1ns / 1ps
module spi_register_access_framer_crc8_tb;
  import srf_pkg::*;

  localparam int MAX_BYTES       = 4;
  localparam int RESET_FRAME_LEN = 10;
  localparam int SETTLE_CYCLES   = 24;
  localparam int CYCLE_LIMIT     = 300000;
  localparam int PHASE_BEATS     = 70;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_wen;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // model copy of the config registers
  logic       crc_on;
  logic [7:0] crc_poly;
  logic [7:0] crc_residue;

  // model copy of the read-gathering state
  int         pend_data_bytes;
  logic       pend_check;
  logic [31:0] gathered_value;
  logic [7:0] gathered_crc;

  out_t expected_beats[$];
  int   useful_beats;
  int   mismatch_count;
  int   cycle_count;
  bit   no_stall;

  spi_register_access_framer_crc8 #(
    .MAX_DATA_BYTES(MAX_BYTES),
    .RESET_BYTE_COUNT(RESET_FRAME_LEN)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_wen(cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("spi_register_access_framer_crc8_tb: FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= no_stall || ($urandom_range(0, 99) >= 13);
  end

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b,
                                           input logic [7:0] poly);
    logic [7:0] c;
    int i;
    c = crc ^ b;
    for (i = 0; i < 8; i++) begin
      if (c[7]) c = (c << 1) ^ poly;
      else c = c << 1;
    end
    return c;
  endfunction

  // check byte that brings the running CRC to the residue, random if none does
  function automatic logic [7:0] find_check(input logic [7:0] crc);
    int x;
    for (x = 0; x < 256; x++) begin
      if (crc8_step(crc, 8'(x), crc_poly) == crc_residue) return 8'(x);
    end
    return 8'($urandom);
  endfunction

  function automatic int count_of(input logic [2:0] c);
    if (c == 3'd0) return 1;
    if (c > MAX_BYTES) return MAX_BYTES;
    return int'(c);
  endfunction

  function automatic in_t make_item(input kind_t k, input logic [5:0] addr,
                                    input logic [2:0] cnt, input logic [31:0] val,
                                    input logic [7:0] rx);
    in_t it;
    it.kind        = k;
    it.reg_address = addr;
    it.byte_count  = cnt;
    it.write_value = val;
    it.rx_byte     = rx;
    return it;
  endfunction

  function automatic logic [2:0] pick_count();
    if ($urandom_range(0, 99) < 85) return 3'($urandom_range(1, MAX_BYTES));
    return 3'($urandom_range(0, 7));
  endfunction

  function automatic in_t random_item(input kind_t k);
    return make_item(k, 6'($urandom), pick_count(), $urandom, 8'($urandom));
  endfunction

  task automatic push_tx(input logic [7:0] b, input logic last);
    out_t e;
    e = '0;
    e.out_kind   = OKIND_TX;
    e.tx_byte    = b;
    e.frame_last = last;
    expected_beats.push_back(e);
  endtask

  task automatic push_result(input logic [31:0] v, input logic err);
    out_t e;
    e = '0;
    e.out_kind   = OKIND_RES;
    e.read_value = v;
    e.crc_error  = err;
    expected_beats.push_back(e);
  endtask

  task automatic clear_read();
    pend_data_bytes = 0;
    pend_check      = 1'b0;
    gathered_value  = '0;
    gathered_crc    = CRC_INIT;
  endtask

  // frame builder / read gatherer: queues the beats one accepted input causes
  task automatic predict_frame(input in_t it);
    int n, total, i;
    logic [7:0] crc, cmd, b;
    n = count_of(it.byte_count);
    total = 1 + n + (crc_on ? 1 : 0);
    if (it.kind != KIND_RX || pend_data_bytes != 0 || pend_check) useful_beats++;
    case (it.kind)
      KIND_RX: begin
        if (pend_data_bytes != 0) begin
          gathered_value = {gathered_value[23:0], it.rx_byte};
          gathered_crc   = crc8_step(gathered_crc, it.rx_byte, crc_poly);
          pend_data_bytes--;
          if (pend_data_bytes == 0 && !pend_check) begin
            push_result(gathered_value, 1'b0);
            clear_read();
          end
        end else if (pend_check) begin
          gathered_crc = crc8_step(gathered_crc, it.rx_byte, crc_poly);
          push_result(gathered_value, gathered_crc != crc_residue);
          clear_read();
        end
      end
      KIND_RESET: begin
        clear_read();
        for (i = 0; i < RESET_FRAME_LEN; i++) push_tx(RESET_BYTE, i == RESET_FRAME_LEN - 1);
      end
      KIND_WRITE: begin
        clear_read();
        cmd = {2'b00, it.reg_address};
        crc = crc8_step(CRC_INIT, cmd, crc_poly);
        push_tx(cmd, total == 1);
        for (i = 0; i < n; i++) begin
          b = 8'(it.write_value >> (8 * (n - 1 - i)));
          crc = crc8_step(crc, b, crc_poly);
          push_tx(b, i + 2 == total);
        end
        if (crc_on) push_tx(~crc, 1'b1);
      end
      default: begin
        clear_read();
        cmd = READ_BIT | {2'b00, it.reg_address};
        for (i = 0; i < total; i++) push_tx((i == 0) ? cmd : FILL_BYTE, i == total - 1);
        pend_data_bytes = n;
        pend_check      = crc_on;
      end
    endcase
  endtask

  task automatic note_mismatch(input string what, input out_t want);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%s: exp kind %0d tx %02h last %0d value %08h crc_err %0d", what,
               want.out_kind, want.tx_byte, want.frame_last, want.read_value, want.crc_error);
      $display("  got kind %0d tx %02h last %0d value %08h crc_err %0d",
               out_data.out_kind, out_data.tx_byte, out_data.frame_last,
               out_data.read_value, out_data.crc_error);
    end
  endtask

  always @(posedge clk) begin : check_beats
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        note_mismatch("output beat with nothing expected", '0);
      end else begin
        want = expected_beats.pop_front();
        if (out_data.out_kind !== want.out_kind || out_data.tx_byte !== want.tx_byte ||
            out_data.frame_last !== want.frame_last ||
            out_data.read_value !== want.read_value ||
            out_data.crc_error !== want.crc_error) begin
          note_mismatch("output beat mismatch", want);
        end
      end
    end
  end

  task automatic send_beat(input in_t it);
    int gap;
    if (!no_stall && $urandom_range(0, 99) < 13) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    predict_frame(it);
  endtask

  // drop valid, wait for every expected beat, then let the sequencer go quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_CRC_ENABLE: crc_on = val[0];
      CFG_CRC_POLY:   crc_poly = val;
      CFG_CRC_RESIDUE: crc_residue = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  // delivers the low n bytes of v, most significant first, plus a check byte if asked
  task automatic send_read_data(input int n, input logic [31:0] v, input bit checked,
                                input bit good_check);
    logic [7:0] crc, b;
    int i;
    crc = CRC_INIT;
    for (i = 0; i < n; i++) begin
      b = 8'(v >> (8 * (n - 1 - i)));
      crc = crc8_step(crc, b, crc_poly);
      send_beat(make_item(KIND_RX, 6'($urandom), 3'($urandom), $urandom, b));
    end
    if (checked) begin
      b = find_check(crc);
      if (!good_check) b = b ^ (8'h01 << $urandom_range(0, 7));
      send_beat(make_item(KIND_RX, 6'($urandom), 3'($urandom), $urandom, b));
    end
  endtask

  task automatic read_transaction(input bit abandon);
    in_t it;
    int n, k;
    bit checked;
    it = random_item(KIND_READ);
    n = count_of(it.byte_count);
    checked = crc_on;
    send_beat(it);
    if (abandon) begin
      k = $urandom_range(0, n + (checked ? 1 : 0) - 1);
      send_read_data(k, $urandom, 1'b0, 1'b0);
      send_beat(random_item(kind_t'($urandom_range(0, 1) ? KIND_WRITE : KIND_READ)));
    end else begin
      send_read_data(n, $urandom, checked, $urandom_range(0, 99) < 80);
    end
  endtask

  task automatic test_plain_frames();
    send_beat(make_item(KIND_WRITE, 6'd0, 3'd1, 32'h0, 8'h00));
    send_beat(make_item(KIND_WRITE, 6'd63, 3'd4, 32'hFFFF_FFFF, 8'hFF));
    send_beat(make_item(KIND_WRITE, 6'd5, 3'd0, $urandom, 8'($urandom)));
    send_beat(make_item(KIND_WRITE, 6'd17, 3'd7, $urandom, 8'($urandom)));
    send_beat(make_item(KIND_READ, 6'd63, 3'd4, 32'h0, 8'h0));
    send_beat(make_item(KIND_RX, 6'd0, 3'd0, 32'h0, 8'hFF));
    send_beat(make_item(KIND_RX, 6'd0, 3'd0, 32'h0, 8'h00));
    send_beat(make_item(KIND_RX, 6'd0, 3'd0, 32'h0, 8'hA5));
    send_beat(make_item(KIND_RX, 6'd0, 3'd0, 32'h0, 8'h5A));
    send_beat(make_item(KIND_READ, 6'd0, 3'd0, $urandom, 8'h0));
    send_read_data(1, 32'h3C, 1'b0, 1'b0);
    // stray byte with no read pending
    send_beat(make_item(KIND_RX, 6'd9, 3'd2, $urandom, 8'h77));
    send_beat(make_item(KIND_RESET, 6'($urandom), 3'($urandom), $urandom, 8'($urandom)));
    settle();
  endtask

  task automatic test_crc_frames();
    write_reg(CFG_CRC_ENABLE, 8'h01);
    send_beat(make_item(KIND_WRITE, 6'h2A, 3'd2, 32'h1234_ABCD, 8'h0));
    send_beat(make_item(KIND_READ, 6'd1, 3'd2, 32'h0, 8'h0));
    send_read_data(2, 32'h1234, 1'b1, 1'b1);
    send_beat(make_item(KIND_READ, 6'd2, 3'd1, 32'h0, 8'h0));
    send_read_data(1, 32'h56, 1'b1, 1'b0);
    // new requests abandon a read in progress
    send_beat(make_item(KIND_READ, 6'd3, 3'd3, 32'h0, 8'h0));
    send_read_data(1, 32'h9A, 1'b0, 1'b0);
    send_beat(make_item(KIND_WRITE, 6'd4, 3'd1, 32'hEE, 8'h0));
    send_beat(make_item(KIND_READ, 6'd5, 3'd4, 32'h0, 8'h0));
    send_read_data(1, 32'h11, 1'b0, 1'b0);
    send_beat(make_item(KIND_RESET, 6'd0, 3'd0, 32'h0, 8'h0));
    send_beat(make_item(KIND_READ, 6'd6, 3'd1, 32'h0, 8'h0));
    send_beat(make_item(KIND_READ, 6'd7, 3'd1, 32'h0, 8'h0));
    send_read_data(1, 32'h42, 1'b1, 1'b1);
    // crc_enable is taken when the read starts, not when its bytes come back
    send_beat(make_item(KIND_READ, 6'd8, 3'd2, 32'h0, 8'h0));
    settle();
    write_reg(CFG_CRC_ENABLE, 8'h00);
    send_read_data(2, 32'hABCD, 1'b1, 1'b1);
    settle();
  endtask

  task automatic run_traffic(input int beats);
    int goal, sel;
    goal = useful_beats + beats;
    while (useful_beats < goal) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) read_transaction(sel < 6);
      else if (sel < 72) send_beat(random_item(KIND_WRITE));
      else if (sel < 80) send_beat(random_item(KIND_RESET));
      else if (sel < 88) send_beat(random_item(KIND_RX));
      else send_beat(random_item(kind_t'($urandom_range(0, 3))));
    end
    settle();
  endtask

  task automatic test_random_traffic();
    write_reg(CFG_CRC_ENABLE, 8'h00);
    write_reg(CFG_CRC_POLY, CRC_POLY_RST);
    write_reg(CFG_CRC_RESIDUE, 8'h00);
    run_traffic(PHASE_BEATS);

    no_stall = 1'b1;
    write_reg(CFG_CRC_ENABLE, 8'h01);
    run_traffic(PHASE_BEATS);
    no_stall = 1'b0;

    write_reg(CFG_CRC_ENABLE, 8'hFF);
    write_reg(CFG_CRC_POLY, 8'hFF);
    write_reg(CFG_CRC_RESIDUE, 8'hFF);
    run_traffic(PHASE_BEATS);

    write_reg(CFG_CRC_POLY, 8'h00);
    write_reg(CFG_CRC_RESIDUE, 8'h00);
    run_traffic(PHASE_BEATS);

    // upper bits set, enable bit clear
    write_reg(CFG_CRC_ENABLE, 8'hFE);
    write_reg(CFG_CRC_POLY, 8'($urandom));
    run_traffic(PHASE_BEATS);

    write_reg(CFG_CRC_ENABLE, 8'($urandom) | 8'h01);
    write_reg(CFG_CRC_POLY, 8'($urandom));
    write_reg(CFG_CRC_RESIDUE, 8'($urandom));
    run_traffic(PHASE_BEATS);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    cfg_wen        = 1'b0;
    cfg_index      = CFG_CRC_ENABLE;
    cfg_data       = '0;
    crc_on         = 1'b0;
    crc_poly       = CRC_POLY_RST;
    crc_residue    = 8'h00;
    useful_beats   = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    no_stall       = 1'b0;
    clear_read();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_plain_frames();
    test_crc_frames();
    test_random_traffic();

    settle();
    if (mismatch_count == 0 && expected_beats.size() == 0) begin
      $display("spi_register_access_framer_crc8_tb: PASS");
    end else begin
      $display("spi_register_access_framer_crc8_tb: FAIL");
    end
    $finish;
  end

endmodule
